>>> hdl/cantp_rx_pkg.sv
// Shared types, codes and constants of the CAN transport receive reassembler.
package cantp_rx_pkg;

  // Largest message the receive buffer can hold
  localparam int unsigned BUFFER_BYTES = 4096;

  localparam logic [7:0] TIMEOUT_RESET = 8'd100;

  // Input kinds (in_tuser)
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_FRAME   = 2'd1;
  localparam logic [1:0] KIND_TX_DONE = 2'd2;

  // Result kinds (out_tuser)
  localparam logic [2:0] RES_PAYLOAD   = 3'd0;
  localparam logic [2:0] RES_COMPLETE  = 3'd1;
  localparam logic [2:0] RES_FLOW_CTRL = 3'd2;
  localparam logic [2:0] RES_ABORT     = 3'd3;
  localparam logic [2:0] RES_CTS       = 3'd4;

  // Frame types, high nibble of byte 0
  localparam logic [3:0] PCI_SINGLE = 4'h0;
  localparam logic [3:0] PCI_FIRST  = 4'h1;
  localparam logic [3:0] PCI_CONSEC = 4'h2;
  localparam logic [3:0] PCI_FLOW   = 4'h3;

  localparam logic [7:0] FC_CONTINUE = 8'h30;

  // Payload bytes carried per frame type
  localparam logic [2:0] SF_MAX_BYTES = 3'd7;
  localparam logic [2:0] FF_MAX_BYTES = 3'd6;
  localparam logic [2:0] CF_MAX_BYTES = 3'd7;

  typedef enum logic [2:0] {
    MODE_WAIT_FIRST = 3'b001,
    MODE_WAIT_FLOW  = 3'b010,
    MODE_WAIT_CF    = 3'b100
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [11:0] bytes_remaining;
    logic [11:0] write_index;
    logic [11:0] total_length;
    logic [3:0]  last_sequence;
    logic        timer_running;
    logic [7:0]  tick_count;
  } rx_state_t;

  // One non-payload result
  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] length;
    logic        fc_error;
  } event_t;

  // Everything one request produces: a run of payload bytes, then up to three events
  typedef struct packed {
    logic [2:0]       pay_cnt;
    logic             pay_from_b2;
    logic [11:0]      pay_start;
    logic [1:0]       ev_cnt;
    event_t [2:0]     ev;
  } plan_t;

endpackage

>>> hdl/cantp_receive_reassembler_unit.sv
// Top level of the CAN transport (ISO-TP style) receive reassembler.
//
// Input stream (in_*): one request per poll tick, per tick carrying a received
// 8-byte CAN frame, or per transmit-complete event; in_tuser gives which.
// Result stream (out_*): payload bytes with their buffer index, message
// complete, flow control (continue or error), abort and clear-to-send, up to
// ten results per request, out_tlast on the final one. A request that causes
// nothing gives no result.
// Config: cfg_wr_en/cfg_wr_data load the timeout in ticks; write it only idle.
// Path: an accepted request is held in the input register, decoded once the
// result sequencer is free and loaded into it; its first result comes from there.
// Throughput: the result sequencer sends one result a cycle while out_tready
// is high; requests with at most one result flow at one a cycle while
// out_tready is high.
// Reset (rst_n low, synchronous): wait-for-first-frame, all counters cleared,
// timeout back to 100 ticks, both channels empty.
// Stall: with out_tready low the current result holds; one further request
// waits in the input register and then in_tready drops.
module cantp_receive_reassembler_unit #(
  parameter int unsigned BUFFER_BYTES = cantp_rx_pkg::BUFFER_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,  // timeout_ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,     // byte0, byte1, ..., byte7 (8 bits each)
  input  logic [1:0]  in_tuser,     // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // byte_index[11:0], byte_value[7:0],
                                    // message_length[11:0], fc_error, 7 zero bits
  output logic [2:0]  out_tuser,    // result_kind
  output logic        out_tlast     // last
);
  import cantp_rx_pkg::*;

  // input register
  logic            in_valid_r;
  logic [1:0]      in_kind_r;
  logic [7:0][7:0] in_frame_r;

  // reassembly state
  rx_state_t  state_r;
  rx_state_t  state_nxt;
  logic [7:0] timeout_r;

  plan_t plan;
  logic  seq_free;
  logic  proc;

  logic [11:0] byte_index;
  logic [7:0]  byte_value;
  logic [11:0] message_length;
  logic        fc_error;

  // a request is decoded once the sequencer is empty or hands over its last result
  assign proc      = in_valid_r & seq_free;
  assign in_tready = ~in_valid_r | proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_kind_r  <= in_tuser;
      in_frame_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode            <= MODE_WAIT_FIRST;
      state_r.bytes_remaining <= '0;
      state_r.write_index     <= '0;
      state_r.total_length    <= '0;
      state_r.last_sequence   <= '0;
      state_r.timer_running   <= 1'b0;
      state_r.tick_count      <= '0;
    end else if (proc) begin
      state_r <= state_nxt;
    end
  end

  cantp_rx_step #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_step (
    .state         (state_r),
    .kind          (in_kind_r),
    .frame         (in_frame_r),
    .timeout_ticks (timeout_r),
    .state_nxt     (state_nxt),
    .plan          (plan)
  );

  cantp_rx_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (proc),
    .plan           (plan),
    .frame          (in_frame_r),
    .free           (seq_free),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .res_kind       (out_tuser),
    .byte_index     (byte_index),
    .byte_value     (byte_value),
    .message_length (message_length),
    .fc_error       (fc_error),
    .last           (out_tlast)
  );

  assign out_tdata = {7'd0, fc_error, message_length, byte_value, byte_index};

  // the timer only runs while a multi-frame message is open
  a_timer_needs_msg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.timer_running |-> (state_r.mode != MODE_WAIT_FIRST))
    else $error("timer running while waiting for a first frame");

  a_idle_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == MODE_WAIT_FIRST) |-> (state_r.write_index == '0))
    else $error("write index not cleared outside a message");

  a_tick_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.timer_running |-> (state_r.tick_count == '0))
    else $error("tick count held while timer stopped");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> in_valid_r)
    else $error("accepted request lost before decode");

endmodule

>>> hdl/cantp_rx_step.sv
// Next-state and result planning for one input request.
module cantp_rx_step #(
  parameter int unsigned BUFFER_BYTES = cantp_rx_pkg::BUFFER_BYTES
) (
  input  cantp_rx_pkg::rx_state_t state,
  input  logic [1:0]              kind,
  input  logic [7:0][7:0]         frame,
  input  logic [7:0]              timeout_ticks,
  output cantp_rx_pkg::rx_state_t state_nxt,
  output cantp_rx_pkg::plan_t     plan
);
  import cantp_rx_pkg::*;

  logic [7:0]  b0;
  logic [3:0]  pci;
  logic [11:0] ff_len;
  logic [3:0]  seq_next;
  logic [2:0]  take;
  logic [7:0]  tick_inc;
  logic [1:0]  fcnt;
  logic        fault;

  function automatic rx_state_t restart_state(rx_state_t s);
    rx_state_t r;
    r               = s;
    r.mode          = MODE_WAIT_FIRST;
    r.write_index   = '0;
    r.timer_running = 1'b0;
    r.tick_count    = '0;
    r.last_sequence = '0;
    return r;
  endfunction

  function automatic rx_state_t abort_state(rx_state_t s);
    rx_state_t r;
    r                 = restart_state(s);
    r.bytes_remaining = '0;
    r.total_length    = '0;
    return r;
  endfunction

  localparam event_t EV_ABORT  = '{kind: RES_ABORT,     length: 12'd0, fc_error: 1'b0};
  localparam event_t EV_FC_ERR = '{kind: RES_FLOW_CTRL, length: 12'd0, fc_error: 1'b1};
  localparam event_t EV_FC_OK  = '{kind: RES_FLOW_CTRL, length: 12'd0, fc_error: 1'b0};
  localparam event_t EV_CTS    = '{kind: RES_CTS,       length: 12'd0, fc_error: 1'b0};

  always_comb begin
    b0        = frame[0];
    pci       = b0[7:4];
    ff_len    = {b0[3:0], frame[1]};
    seq_next  = state.last_sequence + 4'd1;
    state_nxt = state;
    plan      = '0;
    plan.pay_start = state.write_index;
    fcnt      = '0;
    fault     = 1'b0;
    take      = '0;
    tick_inc  = '0;

    if (kind == KIND_TX_DONE) begin
      if (state.mode == MODE_WAIT_FLOW) begin
        state_nxt.mode = MODE_WAIT_CF;
      end
    end else if (kind inside {KIND_TICK, KIND_FRAME}) begin
      if (kind == KIND_FRAME) begin
        state_nxt.tick_count = '0;
        case (pci)
          PCI_SINGLE: begin
            take = (b0 > 8'(SF_MAX_BYTES)) ? SF_MAX_BYTES : b0[2:0];
            state_nxt.total_length = 12'(take);
            plan.pay_cnt   = take;
            plan.pay_start = '0;
            plan.ev[0]     = '{kind: RES_COMPLETE, length: 12'(take), fc_error: 1'b0};
            fcnt           = 2'd1;
          end
          PCI_FIRST, PCI_CONSEC: begin
            case (state.mode)
              MODE_WAIT_FLOW: begin
                state_nxt.mode = MODE_WAIT_CF;
              end
              MODE_WAIT_CF: begin
                if (pci == PCI_CONSEC) begin
                  if (seq_next == b0[3:0]) begin
                    state_nxt.last_sequence = seq_next;
                    take = (state.bytes_remaining < 12'(CF_MAX_BYTES)) ?
                           state.bytes_remaining[2:0] : CF_MAX_BYTES;
                    plan.pay_cnt = take;
                    state_nxt.write_index     = state.write_index + 12'(take);
                    state_nxt.bytes_remaining = state.bytes_remaining - 12'(take);
                  end else begin
                    fault = 1'b1;
                  end
                end
                if (fault || (state_nxt.write_index > state.total_length)) begin
                  state_nxt  = abort_state(state_nxt);
                  plan.ev[0] = EV_ABORT;
                  plan.ev[1] = EV_FC_ERR;
                  fcnt       = 2'd2;
                end else if (state_nxt.bytes_remaining == '0) begin
                  state_nxt  = restart_state(state_nxt);
                  plan.ev[0] = '{kind: RES_COMPLETE, length: state.total_length,
                                 fc_error: 1'b0};
                  fcnt       = 2'd1;
                end
              end
              default: begin
                if (pci == PCI_FIRST) begin
                  if ({1'b0, ff_len} > 13'(BUFFER_BYTES)) begin
                    plan.ev[0] = EV_FC_ERR;
                    fcnt       = 2'd1;
                  end else begin
                    take = (ff_len < 12'(FF_MAX_BYTES)) ? ff_len[2:0] : FF_MAX_BYTES;
                    plan.pay_cnt              = take;
                    plan.pay_from_b2          = 1'b1;
                    state_nxt.mode            = MODE_WAIT_FLOW;
                    state_nxt.total_length    = ff_len;
                    state_nxt.bytes_remaining = ff_len - 12'(take);
                    state_nxt.write_index     = state.write_index + 12'(take);
                    state_nxt.timer_running   = 1'b1;
                    plan.ev[0]                = EV_FC_OK;
                    fcnt                      = 2'd1;
                  end
                end
              end
            endcase
          end
          PCI_FLOW: begin
            if (b0 == FC_CONTINUE) begin
              plan.ev[0] = EV_CTS;
              fcnt       = 2'd1;
            end
          end
          default: begin
          end
        endcase
      end

      // timeout runs after the frame has been handled
      if (state_nxt.timer_running) begin
        tick_inc = (state_nxt.tick_count != 8'hFF) ? state_nxt.tick_count + 8'd1 :
                   state_nxt.tick_count;
        if (tick_inc >= timeout_ticks) begin
          state_nxt = abort_state(state_nxt);
          if (fcnt == 2'd0) begin
            plan.ev[0] = EV_ABORT;
            plan.ev[1] = EV_FC_ERR;
          end else begin
            plan.ev[1] = EV_ABORT;
            plan.ev[2] = EV_FC_ERR;
          end
          fcnt = fcnt + 2'd2;
        end else begin
          state_nxt.tick_count = tick_inc;
        end
      end
    end

    plan.ev_cnt = fcnt;
  end

endmodule

>>> hdl/cantp_rx_seq.sv
// Result register and sequencer: plays out one planned request, a result per cycle while out_tready is high.
module cantp_rx_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  cantp_rx_pkg::plan_t plan,
  input  logic [7:0][7:0]     frame,
  output logic                free,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [2:0]          res_kind,
  output logic [11:0]         byte_index,
  output logic [7:0]          byte_value,
  output logic [11:0]         message_length,
  output logic                fc_error,
  output logic                last
);
  import cantp_rx_pkg::*;

  plan_t           plan_r;
  logic [7:0][7:0] frame_r;
  logic [3:0]      pos_r;
  logic            busy_r;

  logic [3:0] total;
  logic       is_pay;
  logic [1:0] ev_sel;
  logic [2:0] byte_sel;
  event_t     ev;
  logic       done;

  assign total    = {1'b0, plan_r.pay_cnt} + {2'b00, plan_r.ev_cnt};
  assign last     = (pos_r == total - 4'd1);
  assign done     = busy_r & out_tready & last;
  assign free     = ~busy_r | done;
  assign is_pay   = (pos_r < {1'b0, plan_r.pay_cnt});
  assign ev_sel   = 2'(pos_r - {1'b0, plan_r.pay_cnt});
  assign byte_sel = pos_r[2:0] + 3'd1 + {2'b00, plan_r.pay_from_b2};
  assign ev       = (ev_sel != 2'd3) ? plan_r.ev[ev_sel] : '0;
  assign out_tvalid = busy_r;

  always_comb begin
    if (is_pay) begin
      res_kind       = RES_PAYLOAD;
      byte_index     = plan_r.pay_start + {8'd0, pos_r};
      byte_value     = frame_r[byte_sel];
      message_length = '0;
      fc_error       = 1'b0;
    end else begin
      res_kind       = ev.kind;
      byte_index     = '0;
      byte_value     = '0;
      message_length = ev.length;
      fc_error       = ev.fc_error;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else if (load) begin
      busy_r <= (plan.pay_cnt != '0) || (plan.ev_cnt != '0);
      pos_r  <= '0;
    end else if (busy_r && out_tready) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        pos_r <= pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      plan_r  <= plan;
      frame_r <= frame;
    end
  end

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the CAN transport receive reassembler.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cantp_rx_pkg::*;

  // in_tuser value that the block has no use for: it must be ignored
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int MAX_RESULTS   = 10;   // most results one request can cause
  localparam int SETTLE_CYCLES = 8;    // quiet cycles before a register write
  localparam int LONG_HOLD     = 300;  // receiver back-pressure stretch
  localparam int TAIL_CYCLES   = 20;
  localparam int DRAIN_LIMIT   = 5000;

  // What the stimulus side asks the driver to do next
  typedef enum {
    OP_REQUEST,   // offer one request on the input stream
    OP_DRAIN,     // hold the input until every awaited result is in
    OP_CONFIG,    // write timeout_ticks (only ever after a drain)
    OP_HOLD       // ask the receiver for a long stall
  } traffic_op_t;

  typedef struct {
    traffic_op_t op;
    logic [1:0]  kind;
    logic [63:0] frame;    // byte0 in the lowest bits
    logic [7:0]  timeout;
    int          gap;      // idle cycles before the request is offered
  } traffic_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] index;
    logic [7:0]  value;
    logic [11:0] length;
    logic        fc_error;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = KIND_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  cantp_receive_reassembler_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Reassembly predictor: own copy of the receive state and the timeout.
  // ---------------------------------------------------------------------
  mode_t       rx_mode = MODE_WAIT_FIRST;
  logic [11:0] rx_remaining = '0;
  logic [11:0] rx_wr_index = '0;
  logic [11:0] rx_total = '0;
  logic [3:0]  rx_seq = '0;
  logic        rx_timer_on = 1'b0;
  logic [7:0]  rx_ticks = '0;
  logic [7:0]  rx_timeout = TIMEOUT_RESET;

  result_t     request_results[$];   // results of the request being predicted
  result_t     awaited_results[$];   // in order, oldest first

  traffic_t    rx_traffic[$];
  int          long_holds_asked = 0;
  int          long_holds_served = 0;
  int          error_count = 0;
  int          results_seen = 0;

  // Generator-side view
  int          gen_timeout = TIMEOUT_RESET;
  bit          send_calm = 1'b0;
  int          requests_queued = 0;

  task automatic flag_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void note_result(input logic [2:0] kind, input logic [11:0] index,
                                      input logic [7:0] value, input logic [11:0] length,
                                      input logic fc_error);
    result_t r;
    r = '{kind: kind, index: index, value: value, length: length,
          fc_error: fc_error, last: 1'b0};
    if (request_results.size() < MAX_RESULTS)
      request_results.push_back(r);
  endfunction

  // Back to wait-first; length bookkeeping survives
  function automatic void clear_message();
    rx_mode = MODE_WAIT_FIRST;
    rx_wr_index = '0;
    rx_timer_on = 1'b0;
    rx_ticks = '0;
    rx_seq = '0;
  endfunction

  function automatic void abort_message();
    rx_remaining = '0;
    rx_total = '0;
    clear_message();
    note_result(RES_ABORT, '0, '0, '0, 1'b0);
    note_result(RES_FLOW_CTRL, '0, '0, '0, 1'b1);
  endfunction

  // Payload bytes go out until the message has all it asked for
  function automatic void take_bytes(input logic [63:0] frame, input int count,
                                     input int first_byte);
    int i;
    for (i = 0; i < count && rx_remaining != 0; i++) begin
      note_result(RES_PAYLOAD, rx_wr_index, frame[8*(first_byte+i) +: 8], '0, 1'b0);
      rx_wr_index = rx_wr_index + 12'd1;
      rx_remaining = rx_remaining - 12'd1;
    end
  endfunction

  function automatic void reassemble_request(input logic [1:0] kind, input logic [63:0] frame);
    logic [7:0]  pci;
    logic [3:0]  ftype;
    logic [3:0]  next_seq;
    logic [12:0] ff_len;
    logic [11:0] done_len;
    int          sf_len;
    int          i;
    bit          aborted;
    request_results.delete();
    pci = frame[7:0];
    ftype = pci[7:4];
    if (kind == KIND_TX_DONE) begin
      if (rx_mode == MODE_WAIT_FLOW)
        rx_mode = MODE_WAIT_CF;
    end else if (kind != KIND_UNUSED) begin
      if (kind == KIND_FRAME) begin
        rx_ticks = '0;
        if (ftype == PCI_SINGLE) begin
          // length saturates at seven; an open message stays open, but its total takes the new length
          sf_len = (pci > SF_MAX_BYTES) ? int'(SF_MAX_BYTES) : int'(pci);
          rx_total = 12'(sf_len);
          for (i = 0; i < sf_len; i++)
            note_result(RES_PAYLOAD, 12'(i), frame[8*(1+i) +: 8], '0, 1'b0);
          note_result(RES_COMPLETE, '0, '0, 12'(sf_len), 1'b0);
        end else if (ftype == PCI_FIRST || ftype == PCI_CONSEC) begin
          if (rx_mode == MODE_WAIT_FLOW) begin
            rx_mode = MODE_WAIT_CF;
          end else if (rx_mode == MODE_WAIT_CF) begin
            aborted = 1'b0;
            if (ftype == PCI_CONSEC) begin
              next_seq = rx_seq + 4'd1;
              if (next_seq == pci[3:0]) begin
                rx_seq = next_seq;
                take_bytes(frame, int'(CF_MAX_BYTES), 1);
              end else begin
                abort_message();
                aborted = 1'b1;
              end
            end
            if (!aborted) begin
              if (rx_wr_index > rx_total) begin
                abort_message();
              end else if (rx_remaining == 0) begin
                done_len = rx_total;
                clear_message();
                note_result(RES_COMPLETE, '0, '0, done_len, 1'b0);
              end
            end
          end else if (ftype == PCI_FIRST) begin
            ff_len = {1'b0, pci[3:0], frame[15:8]};
            if (ff_len > BUFFER_BYTES) begin
              note_result(RES_FLOW_CTRL, '0, '0, '0, 1'b1);
            end else begin
              rx_remaining = ff_len[11:0];
              rx_total = ff_len[11:0];
              rx_mode = MODE_WAIT_FLOW;
              take_bytes(frame, int'(FF_MAX_BYTES), 2);
              rx_timer_on = 1'b1;
              note_result(RES_FLOW_CTRL, '0, '0, '0, 1'b0);
            end
          end
        end else if (ftype == PCI_FLOW) begin
          if (pci == FC_CONTINUE)
            note_result(RES_CTS, '0, '0, '0, 1'b0);
        end
      end
      // every tick or frame request, after the frame: a running timer counts towards the timeout
      if (rx_timer_on) begin
        if (rx_ticks != 8'd255)
          rx_ticks = rx_ticks + 8'd1;
        if (rx_ticks >= rx_timeout)
          abort_message();
      end
    end
    if (request_results.size() > 0)
      request_results[request_results.size()-1].last = 1'b1;
    foreach (request_results[i])
      awaited_results.push_back(request_results[i]);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: takes the traffic queue in order. A request is predicted at the
  // edge where it is accepted; drains and register writes only happen with
  // the input empty.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : request_driver
    logic     send_next;
    logic     cfg_next;
    traffic_t head;
    int       gap_count;
    int       settle_count;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_wr_en <= 1'b0;
      gap_count = 0;
      settle_count = 0;
    end else begin
      send_next = in_tvalid;
      cfg_next = 1'b0;
      if (in_tvalid && in_tready) begin
        reassemble_request(in_tuser, in_tdata);
        send_next = 1'b0;
      end
      if (!send_next && rx_traffic.size() > 0) begin
        head = rx_traffic[0];
        case (head.op)
          OP_REQUEST: begin
            if (gap_count < head.gap) begin
              gap_count++;
            end else begin
              gap_count = 0;
              in_tdata <= head.frame;
              in_tuser <= head.kind;
              send_next = 1'b1;
              rx_traffic.delete(0);
            end
          end
          OP_DRAIN: begin
            // a request with no result may still be in flight, hence the settle
            if (awaited_results.size() == 0) begin
              settle_count++;
              if (settle_count >= SETTLE_CYCLES) begin
                settle_count = 0;
                rx_traffic.delete(0);
              end
            end else begin
              settle_count = 0;
            end
          end
          OP_CONFIG: begin
            cfg_next = 1'b1;
            cfg_wr_data <= head.timeout;
            rx_timeout = head.timeout;
            rx_traffic.delete(0);
          end
          OP_HOLD: begin
            long_holds_asked++;
            rx_traffic.delete(0);
          end
          default: rx_traffic.delete(0);
        endcase
      end
      in_tvalid <= send_next;
      cfg_wr_en <= cfg_next;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor and result-side back-pressure. Each accepted result is checked
  // against the oldest awaited one, then a random stall is drawn, except in
  // calm stretches. A long hold lets the block fill up.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t seen;
    result_t want;
    int      stall_left;
    int      hold_left;
    bit      rx_calm;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      rx_calm = 1'b0;
    end else begin
      if (long_holds_served != long_holds_asked) begin
        long_holds_served++;
        hold_left = LONG_HOLD;
      end
      if (out_tvalid && out_tready) begin
        seen = '{kind: out_tuser, index: out_tdata[11:0], value: out_tdata[19:12],
                 length: out_tdata[31:20], fc_error: out_tdata[32], last: out_tlast};
        results_seen++;
        if (awaited_results.size() == 0) begin
          flag_error($sformatf("result %0d (kind %0d) with nothing awaited",
                               results_seen, seen.kind));
        end else begin
          want = awaited_results.pop_front();
          if (seen.kind !== want.kind)
            flag_error($sformatf("result %0d kind %0d, want %0d",
                                 results_seen, seen.kind, want.kind));
          if (seen.index !== want.index)
            flag_error($sformatf("result %0d byte_index %0d, want %0d",
                                 results_seen, seen.index, want.index));
          if (seen.value !== want.value)
            flag_error($sformatf("result %0d byte_value 0x%0h, want 0x%0h",
                                 results_seen, seen.value, want.value));
          if (seen.length !== want.length)
            flag_error($sformatf("result %0d message_length %0d, want %0d",
                                 results_seen, seen.length, want.length));
          if (seen.fc_error !== want.fc_error)
            flag_error($sformatf("result %0d fc_error %0b, want %0b",
                                 results_seen, seen.fc_error, want.fc_error));
          if (seen.last !== want.last)
            flag_error($sformatf("result %0d tlast %0b, want %0b",
                                 results_seen, seen.last, want.last));
        end
        if ($urandom_range(0, 24) == 0)
          rx_calm = !rx_calm;
        stall_left = rx_calm ? 0 : $urandom_range(0, 17);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus building blocks
  // ---------------------------------------------------------------------
  function automatic logic [63:0] noise_bytes();
    return {$urandom, $urandom};
  endfunction

  // random payload behind a given protocol control byte
  function automatic logic [63:0] with_pci(input logic [7:0] pci);
    logic [63:0] fill;
    fill = noise_bytes();
    return {fill[63:8], pci};
  endfunction

  task automatic add_request(input logic [1:0] kind, input logic [63:0] frame);
    traffic_t t;
    if ($urandom_range(0, 19) == 0)
      send_calm = !send_calm;
    t.op = OP_REQUEST;
    t.kind = kind;
    t.frame = frame;
    t.timeout = '0;
    t.gap = send_calm ? 0 : $urandom_range(0, 17);
    rx_traffic.push_back(t);
    requests_queued++;
  endtask

  task automatic add_op(input traffic_op_t op, input logic [7:0] timeout);
    traffic_t t;
    t.op = op;
    t.kind = KIND_TICK;
    t.frame = '0;
    t.timeout = timeout;
    t.gap = 0;
    rx_traffic.push_back(t);
  endtask

  task automatic add_config(input int ticks);
    add_op(OP_DRAIN, '0);
    add_op(OP_CONFIG, 8'(ticks));
    gen_timeout = ticks;
  endtask

  // a frame that lands in the middle of a message
  task automatic add_interloper();
    case ($urandom_range(0, 2))
      0: add_request(KIND_FRAME, with_pci({PCI_SINGLE, 4'($urandom)}));
      1: add_request(KIND_FRAME, with_pci(($urandom_range(0, 1) != 0) ? FC_CONTINUE
                                          : {PCI_FLOW, 4'($urandom)}));
      default: add_request(KIND_FRAME, with_pci({4'($urandom_range(4, 15)), 4'($urandom)}));
    endcase
  endtask

  task automatic add_noise();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6)       add_request(KIND_FRAME, noise_bytes());
    else if (r < 8)  add_request(KIND_TICK, noise_bytes());
    else if (r == 8) add_request(KIND_TX_DONE, noise_bytes());
    else             add_request(KIND_UNUSED, noise_bytes());
  endtask

  // First frame, flow-control handshake, consecutive frames in sequence;
  // now and then idle ticks, a stray frame, a timeout run or a bad sequence.
  task automatic add_message();
    int          r;
    int          len;
    int          frames;
    int          ticks;
    logic [11:0] lv;
    logic [3:0]  seq;
    logic [63:0] fill;
    r = $urandom_range(0, 19);
    if (r < 12)      len = $urandom_range(0, 30);
    else if (r < 19) len = $urandom_range(31, 70);
    else             len = $urandom_range(100, 130);   // sequence wraps past 15
    lv = 12'(len);
    fill = noise_bytes();
    add_request(KIND_FRAME, {fill[63:16], lv[7:0], PCI_FIRST, lv[11:8]});
    if ($urandom_range(0, 4) != 0)
      add_request(KIND_TX_DONE, noise_bytes());
    else
      add_request(KIND_FRAME, with_pci({($urandom_range(0, 1) != 0) ? PCI_FIRST : PCI_CONSEC,
                                        4'($urandom)}));
    frames = (len <= 6) ? 1 : len / 7;
    seq = 4'd1;
    for (int k = 0; k < frames; k++) begin
      ticks = (gen_timeout >= 3) ? $urandom_range(0, (gen_timeout > 4) ? 2 : gen_timeout - 2)
                                 : 0;
      repeat (ticks) add_request(KIND_TICK, noise_bytes());
      r = $urandom_range(0, 99);
      if (r < 3 && gen_timeout <= 60)
        repeat (gen_timeout) add_request(KIND_TICK, noise_bytes());
      else if (r < 7)
        add_interloper();
      if ($urandom_range(0, 39) == 0)
        add_request(KIND_FRAME, with_pci({PCI_CONSEC, seq + 4'($urandom_range(1, 15))}));
      else
        add_request(KIND_FRAME, with_pci({PCI_CONSEC, seq}));
      seq = seq + 4'd1;
    end
  endtask

  task automatic random_phase(input int count);
    int stop_at;
    int r;
    stop_at = requests_queued + count;
    while (requests_queued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 65)      add_message();
      else if (r < 82) repeat ($urandom_range(1, 4)) add_noise();
      else if (r < 94) add_request(KIND_FRAME, with_pci({PCI_SINGLE, 4'($urandom)}));
      else             add_op(OP_DRAIN, '0);   // sender waits for every result
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int drain_wait;

    // Directed part, timeout at its reset value
    add_request(KIND_TICK, '0);                        // idle tick: nothing
    add_request(KIND_FRAME, 64'h0);                    // empty single frame
    add_request(KIND_FRAME, 64'hFFFF_FFFF_FFFF_FF07);  // full single frame
    add_request(KIND_FRAME, 64'h00AA_00AA_00AA_000F);  // length saturates at 7
    add_request(KIND_FRAME, {56'h0, FC_CONTINUE});     // clear to send
    add_request(KIND_FRAME, 64'h0000_0000_0000_0031);  // other flow control: ignored
    add_request(KIND_FRAME, 64'hFFFF_FFFF_FFFF_FFFF);  // unknown frame type
    add_request(KIND_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    add_request(KIND_TX_DONE, '0);                     // nothing to release
    // twelve bytes: first frame, a consecutive frame dropped while the flow
    // control is outstanding, then the one that finishes it
    add_request(KIND_FRAME, 64'h6655_4433_2211_0C10);
    add_request(KIND_FRAME, 64'h0102_0304_0506_0721);
    add_request(KIND_FRAME, 64'h7766_5544_3322_1121);
    // sequence error
    add_request(KIND_FRAME, 64'h0000_0000_0000_1410);
    add_request(KIND_TX_DONE, '0);
    add_request(KIND_FRAME, 64'h0000_0000_0000_0023);
    // largest length; a single frame shrinks the total, next frame overruns it
    add_request(KIND_FRAME, 64'hA5A5_A5A5_A5A5_FF1F);
    add_request(KIND_TX_DONE, '0);
    add_request(KIND_FRAME, 64'h0000_0000_C3B2_A103);
    add_request(KIND_FRAME, 64'h5A5A_5A5A_5A5A_5A21);
    // zero-length message closed by a further first frame
    add_request(KIND_FRAME, 64'h0000_0000_0000_0010);
    add_request(KIND_FRAME, 64'h0000_0000_0000_0021);
    add_request(KIND_FRAME, 64'h0000_0000_0000_0010);
    // shortest timeout: the first frame times out on its own tick
    add_config(1);
    add_request(KIND_FRAME, 64'h1234_5678_9ABC_0C10);
    add_request(KIND_TX_DONE, '0);

    // Random part over several timeout settings, extremes included
    add_config(255);
    add_op(OP_HOLD, '0);
    random_phase(40);
    add_config($urandom_range(3, 8));
    random_phase(40);
    add_config(2);
    random_phase(35);
    add_config($urandom_range(10, 40));
    add_op(OP_HOLD, '0);
    random_phase(45);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (rx_traffic.size() != 0 || in_tvalid)
      @(posedge clk);
    drain_wait = 0;
    while (awaited_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", awaited_results.size()));

    if (error_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
hdl/cantp_rx_pkg.sv
hdl/cantp_rx_step.sv
hdl/cantp_rx_seq.sv
hdl/cantp_receive_reassembler_unit.sv
verif/testbench.sv
